### src/caf_pkg.sv
package caf_pkg;

  // operation codes
  typedef enum logic [3:0] {
    CMD_ADD8   = 4'd0,
    CMD_SUB8   = 4'd1,
    CMD_INC8   = 4'd2,
    CMD_DEC8   = 4'd3,
    CMD_ADD16  = 4'd4,
    CMD_SP_E8  = 4'd5,
    CMD_RLCA   = 4'd6,
    CMD_RRCA   = 4'd7,
    CMD_RLA    = 4'd8,
    CMD_RRA    = 4'd9,
    CMD_RLC    = 4'd10,
    CMD_RRC    = 4'd11,
    CMD_DAA    = 4'd12,
    CMD_CPL    = 4'd13,
    CMD_SCF    = 4'd14,
    CMD_CCF    = 4'd15
  } cmd_t;

  localparam int unsigned CMD_W   = 4;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FLAGS_W = 4;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [3:0] DAA_NIBBLE_MAX = 4'd9;
  localparam logic [7:0] DAA_BYTE_MAX   = 8'h99;
  localparam logic [7:0] DAA_CORR_LO    = 8'h06;
  localparam logic [7:0] DAA_CORR_HI    = 8'h60;

  // one operation as held in the input stage
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [WORD_W-1:0]  operand_a;
    logic [WORD_W-1:0]  operand_b;
    logic [FLAGS_W-1:0] flags_in;
  } op_t;

  // one result as held in the output stage
  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic [FLAGS_W-1:0] flags_out;
  } res_t;

endpackage

### src/caf_alu.sv
module caf_alu (
  input  caf_pkg::op_t  op,
  output caf_pkg::res_t res
);
  import caf_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        fc;

  logic [8:0]  add8_sum;
  logic [4:0]  add8_nib;
  logic [8:0]  sub8_dif;
  logic [4:0]  sub8_nib;
  logic [7:0]  inc8_r;
  logic [7:0]  dec8_r;
  logic [16:0] add16_sum;
  logic [12:0] add16_low;
  logic [15:0] sp_sum;
  logic [8:0]  sp_byte;
  logic [4:0]  sp_nib;
  logic [7:0]  rlc_r;
  logic [7:0]  rrc_r;
  logic [7:0]  rl_r;
  logic [7:0]  rr_r;

  logic [7:0]  daa_corr;
  logic [7:0]  daa_r;
  logic        daa_c;

  logic [7:0]  r8;
  logic [15:0] r16;
  logic        use16;
  logic        nz;
  logic        nn;
  logic        nh;
  logic        nc;

  // operand split
  assign a   = op.operand_a[7:0];
  assign b   = op.operand_b[7:0];
  assign a16 = op.operand_a;
  assign b16 = op.operand_b;
  assign fz  = op.flags_in[FLAG_Z];
  assign fn  = op.flags_in[FLAG_N];
  assign fh  = op.flags_in[FLAG_H];
  assign fc  = op.flags_in[FLAG_C];

  // adders and subtractors
  assign add8_sum  = {1'b0, a} + {1'b0, b};
  assign add8_nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
  assign sub8_dif  = {1'b0, a} - {1'b0, b};
  assign sub8_nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]};
  assign inc8_r    = a + 8'd1;
  assign dec8_r    = a - 8'd1;
  assign add16_sum = {1'b0, a16} + {1'b0, b16};
  assign add16_low = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign sp_sum    = a16 + {{8{b[7]}}, b};
  assign sp_byte   = {1'b0, a16[7:0]} + {1'b0, b};
  assign sp_nib    = {1'b0, a16[3:0]} + {1'b0, b[3:0]};

  // rotates
  assign rlc_r = {a[6:0], a[7]};
  assign rrc_r = {a[0], a[7:1]};
  assign rl_r  = {a[6:0], fc};
  assign rr_r  = {fc, a[7:1]};

  // decimal adjust
  always_comb begin
    daa_corr = '0;
    daa_c    = fc;
    if (!fn) begin
      if (fh || (a[3:0] > DAA_NIBBLE_MAX)) begin
        daa_corr = daa_corr | DAA_CORR_LO;
      end
      if (fc || (a > DAA_BYTE_MAX)) begin
        daa_corr = daa_corr | DAA_CORR_HI;
        daa_c    = 1'b1;
      end
      daa_r = a + daa_corr;
    end else begin
      if (fh) begin
        daa_corr = daa_corr | DAA_CORR_LO;
      end
      if (fc) begin
        daa_corr = daa_corr | DAA_CORR_HI;
      end
      daa_r = a - daa_corr;
    end
  end

  // result and flag select
  always_comb begin
    r8    = a;
    r16   = '0;
    use16 = 1'b0;
    nz    = fz;
    nn    = 1'b0;
    nh    = 1'b0;
    nc    = fc;
    unique case (cmd_t'(op.cmd))
      CMD_ADD8: begin
        r8 = add8_sum[7:0];
        nz = (add8_sum[7:0] == 8'd0);
        nh = add8_nib[4];
        nc = add8_sum[8];
      end
      CMD_SUB8: begin
        r8 = sub8_dif[7:0];
        nz = (sub8_dif[7:0] == 8'd0);
        nn = 1'b1;
        nh = sub8_nib[4];
        nc = sub8_dif[8];
      end
      CMD_INC8: begin
        r8 = inc8_r;
        nz = (inc8_r == 8'd0);
        nh = (a[3:0] == 4'hF);
      end
      CMD_DEC8: begin
        r8 = dec8_r;
        nz = (dec8_r == 8'd0);
        nn = 1'b1;
        nh = (a[3:0] == 4'h0);
      end
      CMD_ADD16: begin
        use16 = 1'b1;
        r16   = add16_sum[15:0];
        nh    = add16_low[12];
        nc    = add16_sum[16];
      end
      CMD_SP_E8: begin
        use16 = 1'b1;
        r16   = sp_sum;
        nz    = 1'b0;
        nh    = sp_nib[4];
        nc    = sp_byte[8];
      end
      CMD_RLCA: begin
        r8 = rlc_r;
        nz = 1'b0;
        nc = a[7];
      end
      CMD_RRCA: begin
        r8 = rrc_r;
        nz = 1'b0;
        nc = a[0];
      end
      CMD_RLA: begin
        r8 = rl_r;
        nz = 1'b0;
        nc = a[7];
      end
      CMD_RRA: begin
        r8 = rr_r;
        nz = 1'b0;
        nc = a[0];
      end
      CMD_RLC: begin
        r8 = rlc_r;
        nz = (rlc_r == 8'd0);
        nc = a[7];
      end
      CMD_RRC: begin
        r8 = rrc_r;
        nz = (rrc_r == 8'd0);
        nc = a[0];
      end
      CMD_DAA: begin
        r8 = daa_r;
        nz = (daa_r == 8'd0);
        nn = fn;
        nc = daa_c;
      end
      CMD_CPL: begin
        r8 = ~a;
        nn = 1'b1;
        nh = 1'b1;
      end
      CMD_SCF: begin
        nc = 1'b1;
      end
      CMD_CCF: begin
        nc = ~fc;
      end
    endcase
  end

  assign res.result    = use16 ? r16 : {8'd0, r8};
  assign res.flags_out = {nz, nn, nh, nc};

endmodule

### src/cpu_alu_with_flags_core.sv
// ALU with Z/N/H/C flags for an 8-bit handheld CPU, including DAA.
// Input channel: in_valid with in_cmd, in_operand_a, in_operand_b and
// in_flags_in; a transaction is taken when in_valid is high and in_stall low.
// Result channel: out_valid with out_result and out_flags_out; a transaction
// completes when out_valid is high and out_stall low.
// Path: an accepted input passes through the input register and then the
// result register before it shows on out_valid.
// Throughput: one operation per cycle while out_stall is low; the operation
// is one pass of combinational logic between the input and result registers.
// When the receiver stalls, the result register holds its value, the input
// register keeps one more operation, and in_stall rises only once both are
// full. Nothing is lost or repeated under any stall pattern.
// Reset (rst_n low, synchronous) empties both registers; only the pipeline
// valid bits are reset, the operand and result data are not.
module cpu_alu_with_flags_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [caf_pkg::CMD_W-1:0]     in_cmd,
  input  logic [caf_pkg::WORD_W-1:0]    in_operand_a,
  input  logic [caf_pkg::WORD_W-1:0]    in_operand_b,
  input  logic [caf_pkg::FLAGS_W-1:0]   in_flags_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [caf_pkg::WORD_W-1:0]    out_result,
  output logic [caf_pkg::FLAGS_W-1:0]   out_flags_out
);
  import caf_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  op_t  s1_op_r;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;
  res_t alu_res;
  logic out_free;
  logic s1_move;
  logic in_take;

  // handshake control
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_move       = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_move || (out_valid_r && out_stall);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= '{cmd: in_cmd, operand_a: in_operand_a,
                   operand_b: in_operand_b, flags_in: in_flags_in};
    end
  end

  // operation
  caf_alu u_alu (
    .op  (s1_op_r),
    .res (alu_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= alu_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_res_r.result;
  assign out_flags_out = out_res_r.flags_out;

`ifndef ASSERT_OFF
  // input only backs up when both stages hold a transaction and output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall raised without a full pipeline");

  // a waiting operation moves into an empty result register
  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("operation did not advance to result register");

  // a delivered result with nothing behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after delivery");

  // an accepted transaction always lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted transaction lost");
`endif

endmodule
